### sv/spfir_pkg.sv
package spfir_pkg;

    localparam int ORDER_W   = 5;
    localparam int LEN_W     = 11;
    localparam int SLOT_W    = 5;
    localparam int COEF_W    = 24;
    localparam int SAMPLE_W  = 32;
    localparam int IDX_W     = 10;
    localparam int ACC_W     = 64;
    localparam int FRAC_W    = 19;
    localparam int PROD_W    = COEF_W + SAMPLE_W;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 48;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_FILTER = 1'b1;

    typedef enum logic [1:0] {
        REG_ORDER  = 2'd0,
        REG_LENGTH = 2'd1,
        REG_DIR    = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [ORDER_W-1:0] filter_order;
        logic [LEN_W-1:0]   window_length;
        logic               direction;
    } cfg_t;

endpackage

### sv/spfir_apb_regs.sv
module spfir_apb_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spfir_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [spfir_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [spfir_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output spfir_pkg::cfg_t                     cfg
);

    spfir_pkg::cfg_t  cfg_reg;
    spfir_pkg::cfg_t  cfg_next;
    spfir_pkg::reg_idx_t sel_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign sel_idx = spfir_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (sel_idx)
                spfir_pkg::REG_ORDER:
                    cfg_next.filter_order = pwdata[spfir_pkg::ORDER_W-1:0];
                spfir_pkg::REG_LENGTH:
                    cfg_next.window_length = pwdata[spfir_pkg::LEN_W-1:0];
                spfir_pkg::REG_DIR:
                    cfg_next.direction = pwdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel_idx)
            spfir_pkg::REG_ORDER:
                prdata = spfir_pkg::APB_DATA_W'(cfg_reg.filter_order);
            spfir_pkg::REG_LENGTH:
                prdata = spfir_pkg::APB_DATA_W'(cfg_reg.window_length);
            spfir_pkg::REG_DIR:
                prdata = spfir_pkg::APB_DATA_W'(cfg_reg.direction);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_order  <= '0;
            cfg_reg.window_length <= spfir_pkg::LEN_RESET;
            cfg_reg.direction     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/spectral_fir_filter_core.sv
// a sample request is accepted only in idle; the core then walks the taps with its single
// multiply-accumulate over the tap and history memories, drains the product pipeline and
// registers the result, and takes no new request until it is through; loads are taken in idle
// reset (rst_n, async, active low): order 0, window length 1024, upward direction,
// line counter and history fill count zero; the tap memory holds nothing until loaded
module spectral_fir_filter_core
#(
    parameter int MAX_ORDER = 20,
    parameter int MAX_LINES = 1024
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // apb configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spfir_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [spfir_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [spfir_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    // input requests
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [4:0] coef_slot, [28:5] coef_value, [60:29] sample, [63:61] zero
    input  logic [spfir_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] func
    input  logic                                s_axis_tuser,
    // results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] filtered, [41:32] line_index, [47:42] zero
    output logic [spfir_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int CW = $clog2(MAX_LINES);

    spfir_pkg::cfg_t    cfg;
    spfir_pkg::state_t  state_reg;
    spfir_pkg::state_t  state_next;

    logic signed [spfir_pkg::COEF_W-1:0]    tap_mem [MAX_ORDER];
    logic signed [spfir_pkg::SAMPLE_W-1:0]  hist_mem [MAX_ORDER];

    logic [spfir_pkg::SLOT_W-1:0]           in_slot;
    logic signed [spfir_pkg::COEF_W-1:0]    in_coef;
    logic signed [spfir_pkg::SAMPLE_W-1:0]  in_sample;
    logic                                   in_fire;
    logic                                   tap_we;
    logic [AW-1:0]                          tap_waddr;

    logic [OW-1:0]                          order_eff;
    logic [CW:0]                            len_eff;
    logic [31:0]                            hist_back;
    logic [AW-1:0]                          hist_raddr;
    logic                                   issue;
    logic                                   fin_fire;
    logic                                   hist_ok;

    logic [OW-1:0]                          j_reg;
    logic [OW-1:0]                          j_next;
    logic [AW-1:0]                          wp_reg;
    logic [AW-1:0]                          wp_next;
    logic [CW-1:0]                          line_cnt_reg;
    logic [CW-1:0]                          line_cnt_next;
    logic                                   rd_vld_reg;
    logic                                   prod_vld_reg;
    logic                                   ok_reg;
    logic                                   out_vld_reg;
    logic                                   out_vld_next;

    logic signed [spfir_pkg::SAMPLE_W-1:0]  sample_reg;
    logic signed [spfir_pkg::COEF_W-1:0]    tap_rd_reg;
    logic signed [spfir_pkg::SAMPLE_W-1:0]  hist_rd_reg;
    logic signed [spfir_pkg::SAMPLE_W-1:0]  hist_masked;
    logic signed [spfir_pkg::PROD_W-1:0]    prod_reg;
    logic signed [spfir_pkg::ACC_W-1:0]     acc_reg;
    logic signed [spfir_pkg::ACC_W-1:0]     acc_next;
    logic signed [spfir_pkg::ACC_W-1:0]     acc_rnd;
    logic signed [spfir_pkg::ACC_W-1:0]     y_full;
    logic signed [spfir_pkg::SAMPLE_W-1:0]  y_sat;
    logic                                   is_last;
    logic [spfir_pkg::IDX_W-1:0]            idx;

    logic signed [spfir_pkg::SAMPLE_W-1:0]  out_y_reg;
    logic [spfir_pkg::IDX_W-1:0]            out_idx_reg;
    logic                                   out_last_reg;

    spfir_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_slot   = s_axis_tdata[4:0];
    assign in_coef   = s_axis_tdata[28:5];
    assign in_sample = s_axis_tdata[60:29];

    // effective order and window length after clamping
    assign order_eff = (32'(cfg.filter_order) > 32'(MAX_ORDER)) ? OW'(MAX_ORDER)
                                                                  : OW'(cfg.filter_order);
    always_comb
    begin
        if (cfg.window_length == '0)
            len_eff = (CW+1)'(1);
        else if (32'(cfg.window_length) > 32'(MAX_LINES))
            len_eff = (CW+1)'(MAX_LINES);
        else
            len_eff = (CW+1)'(cfg.window_length);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spfir_pkg::ST_IDLE:
                if (s_axis_tvalid && s_axis_tuser == spfir_pkg::FUNC_FILTER)
                    state_next = spfir_pkg::ST_MAC;
            spfir_pkg::ST_MAC:
                if (j_reg >= order_eff)
                    state_next = spfir_pkg::ST_DRAIN;
            spfir_pkg::ST_DRAIN:
                if (!rd_vld_reg && !prod_vld_reg)
                    state_next = spfir_pkg::ST_FINISH;
            spfir_pkg::ST_FINISH:
                if (!out_vld_reg || m_axis_tready)
                    state_next = spfir_pkg::ST_IDLE;
            default:
                state_next = spfir_pkg::ST_IDLE;
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        s_axis_tready = 1'b0;
        issue         = 1'b0;
        fin_fire      = 1'b0;
        unique case (state_reg)
            spfir_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            spfir_pkg::ST_MAC:    issue = (j_reg < order_eff);
            spfir_pkg::ST_DRAIN:  issue = 1'b0;
            spfir_pkg::ST_FINISH: fin_fire = !out_vld_reg || m_axis_tready;
            default:              s_axis_tready = 1'b0;
        endcase
    end

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign tap_we    = in_fire && s_axis_tuser == spfir_pkg::FUNC_LOAD
                       && in_slot != '0 && 32'(in_slot) <= 32'(MAX_ORDER);
    assign tap_waddr = AW'(in_slot - 5'd1);

    // history is a ring: delay j+1 sits at wp - 1 - j, folded back once into range
    assign hist_back  = 32'(wp_reg) + 32'(MAX_ORDER) - 32'd1 - 32'(j_reg);
    assign hist_raddr = (hist_back >= 32'(MAX_ORDER)) ? AW'(hist_back - 32'(MAX_ORDER))
                                                      : AW'(hist_back);
    // only the samples already seen in this window count as history
    assign hist_ok    = 32'(j_reg) < 32'(line_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (tap_we)
            tap_mem[tap_waddr] <= in_coef;
        if (issue)
            tap_rd_reg <= tap_mem[j_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire && !is_last)
            hist_mem[wp_reg] <= sample_reg;
        if (issue)
            hist_rd_reg <= hist_mem[hist_raddr];
    end

    assign hist_masked = ok_reg ? hist_rd_reg : '0;

    always_comb
    begin
        acc_next = acc_reg;
        if (in_fire && s_axis_tuser == spfir_pkg::FUNC_FILTER)
            acc_next = {{(spfir_pkg::ACC_W-spfir_pkg::SAMPLE_W-spfir_pkg::FRAC_W)
                         {in_sample[spfir_pkg::SAMPLE_W-1]}},
                        in_sample, {spfir_pkg::FRAC_W{1'b0}}};
        else if (prod_vld_reg)
            acc_next = acc_reg + spfir_pkg::ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            sample_reg <= in_sample;
        ok_reg   <= hist_ok;
        prod_reg <= tap_rd_reg * hist_masked;
        acc_reg  <= acc_next;
    end

    // round half up, then saturate
    assign acc_rnd = acc_reg + 64'sd262144;
    assign y_full  = acc_rnd >>> spfir_pkg::FRAC_W;
    always_comb
    begin
        if (y_full > 64'sd2147483647)
            y_sat = 32'sh7fffffff;
        else if (y_full < -64'sd2147483648)
            y_sat = 32'sh80000000;
        else
            y_sat = y_full[spfir_pkg::SAMPLE_W-1:0];
    end

    assign is_last = 32'(line_cnt_reg) >= 32'(len_eff) - 32'd1;
    always_comb
    begin
        if (!cfg.direction)
            idx = spfir_pkg::IDX_W'(line_cnt_reg);
        else if (is_last)
            idx = '0;
        else
            idx = spfir_pkg::IDX_W'(32'(len_eff) - 32'd1 - 32'(line_cnt_reg));
    end

    always_comb
    begin
        j_next        = j_reg;
        wp_next       = wp_reg;
        line_cnt_next = line_cnt_reg;
        if (in_fire)
            j_next = '0;
        else if (issue)
            j_next = j_reg + OW'(1);
        if (fin_fire)
        begin
            if (is_last)
            begin
                line_cnt_next = '0;
            end
            else
            begin
                line_cnt_next = line_cnt_reg + CW'(1);
                wp_next = (32'(wp_reg) == 32'(MAX_ORDER) - 32'd1) ? '0 : wp_reg + AW'(1);
            end
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (fin_fire)
            out_vld_next = 1'b1;
        else if (m_axis_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            out_y_reg    <= y_sat;
            out_idx_reg  <= idx;
            out_last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= spfir_pkg::ST_IDLE;
            j_reg        <= '0;
            wp_reg       <= '0;
            line_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            j_reg        <= j_next;
            wp_reg       <= wp_next;
            line_cnt_reg <= line_cnt_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            out_vld_reg  <= out_vld_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(spfir_pkg::OUT_DATA_W-spfir_pkg::IDX_W-spfir_pkg::SAMPLE_W){1'b0}},
                            out_idx_reg, out_y_reg};
    assign m_axis_tlast  = out_last_reg;

    a_tap_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spfir_pkg::ST_MAC) |-> (j_reg <= order_eff))
        else $error("tap walk ran past the filter order");

    a_finish_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spfir_pkg::ST_FINISH) |-> (!rd_vld_reg && !prod_vld_reg))
        else $error("result taken while products still in flight");

    a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fin_fire |=> m_axis_tvalid)
        else $error("finished sample did not produce a result");

    a_filter_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tuser == spfir_pkg::FUNC_FILTER) |=>
            (state_reg == spfir_pkg::ST_MAC && j_reg == '0))
        else $error("filter request did not start the tap walk");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_TAPS     = 20;
    localparam int MAX_WINDOW   = 1024;
    localparam int ITEM_TARGET  = 1350;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 600000;

    localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

    typedef struct {
        logic               func;
        logic [4:0]         slot;
        logic signed [23:0] coef;
        logic signed [31:0] sample;
    } line_req_t;

    typedef struct {
        logic signed [31:0] filtered;
        logic [9:0]         line_index;
        logic               last;
    } line_out_t;

    logic clk;
    logic rst_n = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    spectral_fir_filter_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predicted filter state
    logic signed [23:0] mdl_taps [MAX_TAPS];
    logic signed [31:0] mdl_hist [MAX_TAPS];
    int unsigned        mdl_count = 0;
    logic [4:0]         mdl_order = '0;
    logic [10:0]        mdl_len   = spfir_pkg::LEN_RESET;
    logic               mdl_dir   = 1'b0;

    line_req_t line_requests [$];
    line_out_t expected_lines [$];

    bit          tap_written [1:MAX_TAPS];
    int          items_sent  = 0;
    int          mismatches  = 0;
    int          tx_gap_max  = 0;
    int          rx_gap_max  = 0;
    int          hold_req    = 0;
    int          hold_seen   = 0;
    int unsigned cycle_count = 0;

    line_req_t tx_cur = '{default: '0};
    logic      tx_offer;
    int        tx_wait = 0;
    line_out_t rx_got, rx_want;
    logic      rx_rdy;
    int        rx_wait = 0;
    int        rx_hold = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic predict_line(input line_req_t rq);
        int unsigned ord, len, idx;
        logic signed [63:0] acc, tap, hist, y;
        bit fin;
        line_out_t res;
        if (rq.func == spfir_pkg::FUNC_LOAD)
        begin
            if (rq.slot >= 1 && rq.slot <= MAX_TAPS)
                mdl_taps[rq.slot - 1] = rq.coef;
        end
        else
        begin
            ord = (mdl_order > MAX_TAPS) ? MAX_TAPS : mdl_order;
            len = (mdl_len == 0) ? 1 : (mdl_len > MAX_WINDOW) ? MAX_WINDOW : mdl_len;
            acc = rq.sample;
            acc = acc * 64'sd524288;
            for (int i = 0; i < ord; i++)
            begin
                tap  = mdl_taps[i];
                hist = mdl_hist[i];
                acc  = acc + tap * hist;
            end
            // round half up, then clamp to 32 bits
            y = (acc + 64'sd262144) >>> 19;
            if (y > SAT_HI)
                y = SAT_HI;
            if (y < SAT_LO)
                y = SAT_LO;
            fin = (mdl_count >= len - 1);
            if (mdl_dir)
                idx = fin ? 0 : len - 1 - mdl_count;
            else
                idx = mdl_count;
            res.filtered   = y[31:0];
            res.line_index = idx[9:0];
            res.last       = fin;
            expected_lines.push_back(res);
            if (fin)
            begin
                foreach (mdl_hist[i])
                    mdl_hist[i] = '0;
                mdl_count = 0;
            end
            else
            begin
                for (int i = MAX_TAPS - 1; i > 0; i--)
                    mdl_hist[i] = mdl_hist[i - 1];
                mdl_hist[0] = rq.sample;
                mdl_count++;
            end
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            tx_offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_line(tx_cur);
                tx_offer = 1'b0;
                tx_wait  = $urandom_range(0, tx_gap_max);
            end
            if (!tx_offer)
            begin
                if (tx_wait > 0)
                    tx_wait--;
                else if (line_requests.size() > 0)
                begin
                    tx_cur   = line_requests.pop_front();
                    tx_offer = 1'b1;
                end
            end
            s_axis_tvalid <= tx_offer;
            s_axis_tdata  <= {3'b000, tx_cur.sample, tx_cur.coef, tx_cur.slot};
            s_axis_tuser  <= tx_cur.func;
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                rx_got.filtered   = m_axis_tdata[31:0];
                rx_got.line_index = m_axis_tdata[41:32];
                rx_got.last       = m_axis_tlast;
                if (expected_lines.size() == 0)
                begin
                    $display("%0t: result with nothing pending: filtered %0d index %0d last %0b",
                             $time, rx_got.filtered, rx_got.line_index, rx_got.last);
                    mismatches++;
                end
                else
                begin
                    rx_want = expected_lines.pop_front();
                    if (rx_got.filtered !== rx_want.filtered)
                    begin
                        $display("%0t: filtered mismatch, expected %0d, got %0d",
                                 $time, rx_want.filtered, rx_got.filtered);
                        mismatches++;
                    end
                    if (rx_got.line_index !== rx_want.line_index)
                    begin
                        $display("%0t: line_index mismatch, expected %0d, got %0d",
                                 $time, rx_want.line_index, rx_got.line_index);
                        mismatches++;
                    end
                    if (rx_got.last !== rx_want.last)
                    begin
                        $display("%0t: last mismatch, expected %0b, got %0b",
                                 $time, rx_want.last, rx_got.last);
                        mismatches++;
                    end
                end
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                rx_hold   = HOLD_CYCLES;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                rx_rdy = 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                rx_rdy = 1'b0;
            end
            else
                rx_rdy = 1'b1;
            m_axis_tready <= rx_rdy;
        end
    end

    task automatic write_reg(input spfir_pkg::reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            spfir_pkg::REG_ORDER:  mdl_order = val[4:0];
            spfir_pkg::REG_LENGTH: mdl_len   = val[10:0];
            spfir_pkg::REG_DIR:    mdl_dir   = val[0];
            default:    ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_window(input int order_v, input int len_v, input int dir_v);
        write_reg(spfir_pkg::REG_ORDER, order_v);
        write_reg(spfir_pkg::REG_LENGTH, len_v);
        write_reg(spfir_pkg::REG_DIR, dir_v);
    endtask

    task automatic queue_item(input logic func, input int slot_v,
                              input logic [23:0] coef_v, input logic [31:0] samp_v);
        line_req_t rq;
        rq.func   = func;
        rq.slot   = slot_v[4:0];
        rq.coef   = coef_v;
        rq.sample = samp_v;
        line_requests.push_back(rq);
        if (func == spfir_pkg::FUNC_FILTER)
            items_sent++;
        else if (rq.slot >= 1 && rq.slot <= MAX_TAPS)
        begin
            tap_written[rq.slot] = 1'b1;
            items_sent++;
        end
    endtask

    // block the caller until every request has been answered and the core is quiet
    task automatic wait_idle();
        do
            @(negedge clk);
        while (line_requests.size() != 0 || s_axis_tvalid || expected_lines.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom_range(0, 2000) - 1000;
            4:       return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [23:0] rand_coef();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'h007F_FFFF;
            1:       v = 32'h0080_0000;
            2, 3, 4: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            5, 6:    v = $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
            default: v = $urandom();
        endcase
        return v[23:0];
    endfunction

    function automatic int pick_gap();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 19;
            default: return $urandom_range(1, 19);
        endcase
    endfunction

    initial
    begin
        int order_v, len_v, dir_v, eff, nitems, r, phase;
        foreach (mdl_taps[i])
        begin
            mdl_taps[i] = '0;
            mdl_hist[i] = '0;
        end
        foreach (tap_written[i])
            tap_written[i] = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full-scale taps, bad slots, saturation in both directions
        tx_gap_max <= 3;
        rx_gap_max <= 3;
        set_window(3, 5, 0);
        queue_item(spfir_pkg::FUNC_LOAD, 1, 24'h7F_FFFF, $urandom());
        queue_item(spfir_pkg::FUNC_LOAD, 2, 24'h80_0000, $urandom());
        queue_item(spfir_pkg::FUNC_LOAD, 3, 24'hFF_FFFF, $urandom());
        queue_item(spfir_pkg::FUNC_LOAD, 0, 24'h12_3456, $urandom());
        queue_item(spfir_pkg::FUNC_LOAD, 21, 24'h7F_FFFF, $urandom());
        queue_item(spfir_pkg::FUNC_LOAD, 31, 24'h80_0000, $urandom());
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, 32'h7FFF_FFFF);
        queue_item(spfir_pkg::FUNC_FILTER, 31, 24'hFF_FFFF, 32'h7FFF_FFFF);
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, 32'h8000_0000);
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, 32'h0000_0000);
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, 32'hFFFF_FFFF);
        wait_idle();

        // rounding at exactly one half, positive and negative
        tx_gap_max <= 0;
        rx_gap_max <= 0;
        set_window(1, 4, 0);
        queue_item(spfir_pkg::FUNC_LOAD, 1, 24'h00_0001, $urandom());
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, 32'h0004_0000);
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, 32'h0000_0000);
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, 32'hFFFC_0000);
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, 32'h0000_0000);
        wait_idle();

        // one-line windows, downward
        set_window(0, 1, 1);
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, 32'd7);
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, -32'sd7);
        wait_idle();

        // window shrunk below the current count
        tx_gap_max <= 19;
        rx_gap_max <= 19;
        set_window(2, 10, 1);
        repeat (4) queue_item(spfir_pkg::FUNC_FILTER, $urandom(), 24'($urandom()),
                              rand_sample());
        wait_idle();
        write_reg(spfir_pkg::REG_LENGTH, 2);
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, rand_sample());
        wait_idle();

        // zero length acts as one, oversize length acts as the maximum
        write_reg(spfir_pkg::REG_LENGTH, 0);
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, rand_sample());
        wait_idle();
        write_reg(spfir_pkg::REG_LENGTH, 2047);
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, rand_sample());
        queue_item(spfir_pkg::FUNC_FILTER, 0, 24'h0, rand_sample());
        wait_idle();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 9);
            order_v = (r == 0) ? 0 : (r == 1) ? 20 : (r == 2) ? $urandom_range(21, 31)
                                                           : $urandom_range(1, 20);
            r = $urandom_range(0, 11);
            len_v = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 1024
                  : (r == 3) ? $urandom_range(1025, 2047) : $urandom_range(2, 40);
            dir_v = $urandom_range(0, 1);
            set_window(order_v, len_v, dir_v);

            rx_gap_max <= pick_gap();
            if (phase == 2 || phase % 12 == 7)
            begin
                // receiver holds off while the sender keeps pushing
                tx_gap_max <= 0;
                hold_req   <= hold_req + 1;
            end
            else
                tx_gap_max <= pick_gap();

            eff = (order_v > MAX_TAPS) ? MAX_TAPS : order_v;
            for (int s = 1; s <= eff; s++)
                if (!tap_written[s])
                    queue_item(spfir_pkg::FUNC_LOAD, s, rand_coef(), $urandom());

            nitems = $urandom_range(15, 60);
            repeat (nitems)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    queue_item(spfir_pkg::FUNC_LOAD, $urandom_range(1, 20), rand_coef(),
                               $urandom());
                else if (r < 15)
                    queue_item(spfir_pkg::FUNC_LOAD,
                               $urandom_range(0, 1) ? 0 : $urandom_range(21, 31),
                               24'($urandom()), $urandom());
                else
                    queue_item(spfir_pkg::FUNC_FILTER, $urandom(), 24'($urandom()),
                               rand_sample());
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        if (mismatches == 0 && expected_lines.size() == 0)
            $display("testbench passed");
        else
        begin
            if (expected_lines.size() != 0)
                $display("%0t: %0d expected results never arrived",
                         $time, expected_lines.size());
            $display("testbench failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/spfir_pkg.sv
sv/spfir_apb_regs.sv
sv/spectral_fir_filter_core.sv
dv/testbench.sv
